// File: design/qas_pkg.sv
`timescale 1ns / 1ps
package qas_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast value
        logic shift;  // move contents one cell toward the head
    } t_cell_ctrl;

endpackage

// File: design/quicksort_ascending_sorter.sv
`timescale 1ns / 1ps
// Sorts a set of up to CAPACITY signed 32-bit values into ascending order. Values are
// taken one per cycle (start high, busy low); each is placed at once into a sorted row of
// CAPACITY cells. The request with i_is_last high closes the set; from the next cycle
// the block raises busy and shows the set on the result ports, one value per cycle and
// one per stored value, head of the row first, with o_valid as strobe and o_end_of_set
// on the final one. The receiver cannot stall: each result is there for exactly one
// cycle. Values that arrive while the row is full are dropped and o_overflowed is set
// on every result of that set. A new set may start in the cycle after the last result.
module quicksort_ascending_sorter #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  qas_pkg::t_value     i_value,
    input  logic                i_is_last,
    output logic                o_valid,
    output qas_pkg::t_value     o_sorted_value,
    output logic                o_end_of_set,
    output logic                o_overflowed
);
    import qas_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic S_LOAD = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;
    logic          r_ovf;
    logic          n_ovf;

    logic          w_accept;
    logic          w_full;
    t_cell_ctrl    w_ctrl;
    t_value        w_val   [CAPACITY];
    logic          w_valid [CAPACITY];
    logic          w_gt    [CAPACITY];

    assign busy     = (r_state == S_EMIT);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));

    assign w_ctrl.load  = w_accept && !w_full;
    assign w_ctrl.shift = (r_state == S_EMIT);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        qas_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_value),
            .i_prev_gt    ((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .i_prev_val   (w_val[(g == 0) ? 0 : g - 1]),
            .i_prev_valid ((g == 0) ? 1'b0 : w_valid[(g == 0) ? 0 : g - 1]),
            .i_next_val   (w_val[(g == CAPACITY - 1) ? g : g + 1]),
            .i_next_valid ((g == CAPACITY - 1) ? 1'b0
                                               : w_valid[(g == CAPACITY - 1) ? g : g + 1]),
            .o_val        (w_val[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    assign o_valid        = (r_state == S_EMIT);
    assign o_sorted_value = w_val[0];
    assign o_end_of_set   = (r_left == CW'(1));
    assign o_overflowed   = r_ovf;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        n_ovf   = r_ovf;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_is_last) begin
                        n_left  = w_full ? r_count : r_count + CW'(1);
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_left  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_ovf   <= n_ovf;
        end
    end

    a_closing_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_is_last |=> o_valid)
        else $error("closing request did not start output");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_valid[0])
        else $error("result taken from an empty cell");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_set |=> o_valid && (o_sorted_value >= $past(o_sorted_value)))
        else $error("results out of order");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_set |=> !o_valid && (r_count == '0))
        else $error("set not closed after final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");

endmodule

// File: design/qas_cell.sv
`timescale 1ns / 1ps
module qas_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qas_pkg::t_cell_ctrl i_ctrl,
    input  qas_pkg::t_value     i_value,
    input  logic                i_prev_gt,
    input  qas_pkg::t_value     i_prev_val,
    input  logic                i_prev_valid,
    input  qas_pkg::t_value     i_next_val,
    input  logic                i_next_valid,
    output qas_pkg::t_value     o_val,
    output logic                o_valid,
    output logic                o_gt
);
    import qas_pkg::*;

    t_value r_val;
    t_value n_val;
    logic   r_valid;
    logic   n_valid;

    // An empty cell counts as greater than anything, so the chain stays sorted
    assign o_gt    = !r_valid || (r_val > i_value);
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end else if (i_ctrl.load && o_gt) begin
            if (i_prev_gt) begin
                n_val   = i_prev_val;
                n_valid = i_prev_valid;
            end else begin
                n_val   = i_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
